[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// deq_pkg: shared types and codes for the double-ended queue unit
// used by deq_cell and double_ended_queue_unit; no dependencies
package deq_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROTATE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage
`default_nettype wire

[rtl/deq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// deq_cell: one storage cell of the queue chain, cell 0 holds the front
// depends on deq_pkg
module deq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire                        clk,
  input  wire  deq_pkg::cell_ctrl_t  ctrl,
  input  wire  [CW-1:0]              count,
  input  wire  [deq_pkg::DATA_W-1:0] left_in,
  input  wire  [deq_pkg::DATA_W-1:0] right_in,
  output logic [deq_pkg::DATA_W-1:0] q
);
  import deq_pkg::*;

  logic [DATA_W-1:0] q_next;

  // pick the new contents from the neighbors or the broadcast value
  always_comb begin
    q_next = q;
    unique case (ctrl.cmd)
      CMD_HOLD: q_next = q;
      CMD_PUSH_FRONT: q_next = left_in;
      CMD_PUSH_BACK: begin
        if (count == CW'(IDX)) q_next = ctrl.value;
      end
      CMD_POP_FRONT: q_next = right_in;
      CMD_ROTATE: begin
        // front item moves to the back slot, the rest move one toward the front
        if (count == CW'(IDX + 1)) q_next = ctrl.value;
        else if (count > CW'(IDX + 1)) q_next = right_in;
      end
      default: q_next = q;
    endcase
  end

  // contents need no reset
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

[rtl/double_ended_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// double_ended_queue_unit: deque of signed 32-bit values in a chain of cells
// depends on deq_pkg and deq_cell
// push and pop: result in the output register next cycle, taken only while the output is free
// dump of n entries: once accepted, one result per cycle while the output is free, n in all,
//   while the chain rotates once per result; input is held off meanwhile
// reset (rst, synchronous): queue empty, front at cell 0, cell contents not cleared
module double_ended_queue_unit #(
  parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [deq_pkg::DATA_W-1:0]   s_tdata,  // [31:0] value
  input  wire  [deq_pkg::KIND_W-1:0]   s_tuser,  // [2:0] kind
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [deq_pkg::DATA_W-1:0]   m_tdata,  // [31:0] data
  output logic [deq_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
  output logic                         m_tlast
);
  import deq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     dump_idx, dump_idx_next;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cells [CAPACITY];
  logic [DATA_W-1:0] back_value;
  logic              in_fire;
  logic              out_free;
  logic              load_out;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0] out_data;
  logic              out_last;

  // cell chain, cell 0 is the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = ctrl.value;
    end else begin : g_mid
      assign left_in = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cells[i+1];
    end
    deq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (cells[i])
    );
  end

  // back entry select, one-hot and-or over the cells
  always_comb begin
    back_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_value = back_value | (cells[i] & {DATA_W{count == CW'(i + 1)}});
    end
  end

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  // request decode and dump sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    ctrl.cmd      = CMD_HOLD;
    ctrl.value    = s_tdata;
    load_out      = 1'b0;
    out_status    = STATUS_OK;
    out_data      = '0;
    out_last      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_tuser)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              load_out = 1'b1;
              if (count == CW'(CAPACITY)) begin
                out_status = STATUS_FULL;
              end else begin
                ctrl.cmd   = (s_tuser == KIND_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                count_next = count + CW'(1);
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              load_out = 1'b1;
              if (count == '0) begin
                out_status = STATUS_EMPTY;
              end else begin
                count_next = count - CW'(1);
                if (s_tuser == KIND_POP_FRONT) begin
                  out_data = cells[0];
                  ctrl.cmd = CMD_POP_FRONT;
                end else begin
                  out_data = back_value;
                end
              end
            end
            KIND_DUMP: begin
              if (count == '0) begin
                load_out   = 1'b1;
                out_status = STATUS_EMPTY;
              end else begin
                state_next    = ST_DUMP;
                dump_idx_next = '0;
              end
            end
            default: ;  // unused kinds give no result
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_data   = cells[0];
          out_last   = (CW'(dump_idx) == count - CW'(1));
          ctrl.cmd   = CMD_ROTATE;
          ctrl.value = cells[0];
          if (out_last) state_next = ST_IDLE;
          else dump_idx_next = dump_idx + IW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dump_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_data;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  // occupancy never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // no request taken while a dump walks the chain
  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> !s_tready)
    else $error("input accepted during dump");

  // occupancy does not change while dumping
  a_dump_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> $stable(count))
    else $error("entry count changed during dump");

  // the final dump item ends the dump
  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP && load_out && out_last) |=> (state == ST_IDLE))
    else $error("dump did not finish after its final item");

endmodule
`default_nettype wire
